// ===== rtl/dcam_pkg.sv =====
// Package for the dual channel average meter: widths, register codes,
// the job record passed from front to back, and the back end state type.
// No dependencies.
`default_nettype none

package dcam_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int CNT_W       = 8;
  localparam int SCL_W       = 8;
  localparam int SUM_W       = SAMPLE_W + CNT_W;
  localparam int PROD_W      = SUM_W + SCL_W;
  localparam int QUO_W       = PROD_W - 2;
  localparam int AVG_W       = 16;
  localparam int DIG_W       = 4;
  localparam int NUM_DIGITS  = 5;
  localparam int BCD_W       = DIG_W * NUM_DIGITS;
  localparam int DIV_STEPS   = QUO_W;
  localparam int BCD_STEPS   = AVG_W;
  localparam int IT_W        = $clog2(DIV_STEPS);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 4;

  localparam logic [CNT_W-1:0] BLEN_RESET   = CNT_W'(250);
  localparam logic [SCL_W-1:0] VSCALE_RESET = SCL_W'(11);
  localparam logic [SCL_W-1:0] CSCALE_RESET = SCL_W'(10);

  typedef enum logic [1:0] {
    REG_BLOCK_LENGTH  = 2'd0,
    REG_VOLTAGE_SCALE = 2'd1,
    REG_CURRENT_SCALE = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic             is_voltage;
    logic [SUM_W-1:0] sum;
    logic [SCL_W-1:0] scale;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_BCD,
    ST_DONE
  } calc_state_e;

endpackage

`default_nettype wire

// ===== rtl/dcam_smp_if.sv =====
// Input channel interface: one converter sample per word.
// Depends on dcam_pkg.
`default_nettype none

interface dcam_smp_if;
  logic                          valid;
  logic                          ready;
  logic [dcam_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/dcam_res_if.sv =====
// Output channel interface: one average and three of its decimal digits per word.
// Depends on dcam_pkg.
`default_nettype none

interface dcam_res_if;
  logic                       valid;
  logic                       ready;
  logic                       is_voltage;
  logic [dcam_pkg::AVG_W-1:0] average;
  logic [dcam_pkg::DIG_W-1:0] digit_thousands;
  logic [dcam_pkg::DIG_W-1:0] digit_hundreds;
  logic [dcam_pkg::DIG_W-1:0] digit_tens;

  modport source (output valid, output is_voltage, output average,
                  output digit_thousands, output digit_hundreds,
                  output digit_tens, input ready);
  modport sink (input valid, input is_voltage, input average,
                input digit_thousands, input digit_hundreds,
                input digit_tens, output ready);
endinterface

`default_nettype wire

// ===== rtl/dual_channel_average_meter.sv =====
// A word that completes a block passes to its result word through the job queue, a multiply
// step, a serial divider (one quotient bit per cycle), a digit unit (one digit shift per cycle)
// and the output register. Throughput: samples are taken every cycle while the two-entry job
// queue has room; the back end takes a new block from the queue only when done with the last,
// and waits while its output word is not taken. Reset clears sums and counts, starts on the
// current channel, and loads block length 250, voltage scale 11 and current scale 10.
`default_nettype none

module dual_channel_average_meter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  dcam_smp_if.sink                          smp_i,
  dcam_res_if.source                        res_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dcam_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dcam_pkg::DATA_W-1:0]  pwdata,
  output logic [dcam_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import dcam_pkg::*;

  logic [CNT_W-1:0] blen_q;
  logic [SCL_W-1:0] vscale_q;
  logic [SCL_W-1:0] cscale_q;
  cfg_reg_e         reg_sel;
  logic             wr_en;
  logic             q_full;
  logic             push;
  job_t             push_job;
  logic             head_valid;
  job_t             head_job;
  logic             pop;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q   <= BLEN_RESET;
      vscale_q <= VSCALE_RESET;
      cscale_q <= CSCALE_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BLOCK_LENGTH:  blen_q   <= pwdata[CNT_W-1:0];
        REG_VOLTAGE_SCALE: vscale_q <= pwdata[SCL_W-1:0];
        REG_CURRENT_SCALE: cscale_q <= pwdata[SCL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_LENGTH:  prdata = DATA_W'(blen_q);
      REG_VOLTAGE_SCALE: prdata = DATA_W'(vscale_q);
      REG_CURRENT_SCALE: prdata = DATA_W'(cscale_q);
      default:           prdata = '0;
    endcase
  end

  dcam_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .smp_i    (smp_i),
    .blen_i   (blen_q),
    .vscale_i (vscale_q),
    .cscale_i (cscale_q),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  dcam_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  dcam_calc u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

// ===== rtl/dcam_front.sv =====
// Front end: takes samples, alternates channels, accumulates sums and counts,
// and emits a job when a channel completes its block. Depends on dcam_pkg.
`default_nettype none

module dcam_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  dcam_smp_if.sink                       smp_i,
  input  wire logic [dcam_pkg::CNT_W-1:0] blen_i,
  input  wire logic [dcam_pkg::SCL_W-1:0] vscale_i,
  input  wire logic [dcam_pkg::SCL_W-1:0] cscale_i,
  input  wire logic                      q_full_i,
  output logic                           push_o,
  output dcam_pkg::job_t                 job_o
);
  import dcam_pkg::*;

  logic             chan_q, chan_d;
  logic [SUM_W-1:0] vsum_q, vsum_d, csum_q, csum_d;
  logic [CNT_W-1:0] vcnt_q, vcnt_d, ccnt_q, ccnt_d;
  logic [SUM_W-1:0] new_sum;
  logic [CNT_W-1:0] new_cnt;
  logic [CNT_W-1:0] limit;
  logic             accept;
  logic             done;

  assign smp_i.ready = !q_full_i;
  assign accept      = smp_i.valid && !q_full_i;
  assign limit       = (blen_i == '0) ? CNT_W'(1) : blen_i;

  always_comb begin
    new_sum = (chan_q ? vsum_q : csum_q) + SUM_W'(smp_i.sample);
    new_cnt = (chan_q ? vcnt_q : ccnt_q) + CNT_W'(1);
    done    = (new_cnt >= limit);

    chan_d = chan_q;
    vsum_d = vsum_q;
    csum_d = csum_q;
    vcnt_d = vcnt_q;
    ccnt_d = ccnt_q;
    if (accept) begin
      chan_d = !chan_q;
      if (chan_q) begin
        vsum_d = done ? '0 : new_sum;
        vcnt_d = done ? '0 : new_cnt;
      end else begin
        csum_d = done ? '0 : new_sum;
        ccnt_d = done ? '0 : new_cnt;
      end
    end

    push_o           = accept && done;
    job_o.is_voltage = chan_q;
    job_o.sum        = new_sum;
    job_o.scale      = chan_q ? vscale_i : cscale_i;
    job_o.count      = new_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= 1'b0;
      vsum_q <= '0;
      csum_q <= '0;
      vcnt_q <= '0;
      ccnt_q <= '0;
    end else begin
      chan_q <= chan_d;
      vsum_q <= vsum_d;
      csum_q <= csum_d;
      vcnt_q <= vcnt_d;
      ccnt_q <= ccnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcam_queue.sv =====
// Short job queue between the front end and the arithmetic back end.
// Depends on dcam_pkg.
`default_nettype none

module dcam_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dcam_pkg::job_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output dcam_pkg::job_t      head_o
);
  import dcam_pkg::*;

  job_t               entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_pop;

  assign full_o       = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + Q_PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("Job pushed into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("Queue fill count exceeds its depth.");

endmodule

`default_nettype wire

// ===== rtl/dcam_calc.sv =====
// Back end: scales the block sum, divides by the count one quotient bit per cycle,
// saturates, converts to decimal digits and holds the result word. Depends on dcam_pkg.
`default_nettype none

module dcam_calc (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  input  wire dcam_pkg::job_t head_i,
  output logic                pop_o,
  dcam_res_if.source          res_o
);
  import dcam_pkg::*;

  calc_state_e       state_q, state_d;
  logic              isv_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SCL_W-1:0]  scale_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [QUO_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [IT_W-1:0]   it_q;
  logic [AVG_W-1:0]  avg_q;
  logic [AVG_W-1:0]  bin_q;
  logic [BCD_W-1:0]  bcd_q;
  logic              out_valid_q;
  logic              out_isv_q;
  logic [AVG_W-1:0]  out_avg_q;
  logic [BCD_W-1:0]  out_bcd_q;

  logic [PROD_W-1:0] prod;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [CNT_W-1:0]  rem_next;
  logic [QUO_W-1:0]  quo_next;
  logic [AVG_W-1:0]  sat_avg;
  logic [BCD_W-1:0]  bcd_adj;
  logic              div_last;
  logic              bcd_last;
  logic              out_free;
  logic              load_out;

  always_comb begin
    prod     = PROD_W'(sum_q) * PROD_W'(scale_q);
    trial    = {rem_q, quo_q[QUO_W-1]};
    qbit     = (trial >= {1'b0, cnt_q});
    rem_next = qbit ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
    quo_next = {quo_q[QUO_W-2:0], qbit};
    sat_avg  = (quo_next[QUO_W-1:AVG_W] != '0) ? '1 : quo_next[AVG_W-1:0];
    for (int d = 0; d < NUM_DIGITS; d++) begin
      bcd_adj[d*DIG_W +: DIG_W] = (bcd_q[d*DIG_W +: DIG_W] >= DIG_W'(5)) ?
          bcd_q[d*DIG_W +: DIG_W] + DIG_W'(3) : bcd_q[d*DIG_W +: DIG_W];
    end
    div_last = (it_q == IT_W'(DIV_STEPS - 1));
    bcd_last = (it_q == IT_W'(BCD_STEPS - 1));
    out_free = !out_valid_q || res_o.ready;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (head_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (div_last) state_d = ST_BCD;
      ST_BCD:  if (bcd_last) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == ST_IDLE) && head_valid_i;
    load_out = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        isv_q   <= head_i.is_voltage;
        sum_q   <= head_i.sum;
        scale_q <= head_i.scale;
        cnt_q   <= head_i.count;
      end
      ST_MUL: begin
        quo_q <= prod[PROD_W-1:2];
        rem_q <= '0;
        it_q  <= '0;
      end
      ST_DIV: begin
        quo_q <= quo_next;
        rem_q <= rem_next;
        it_q  <= div_last ? '0 : it_q + IT_W'(1);
        if (div_last) begin
          avg_q <= sat_avg;
          bin_q <= sat_avg;
          bcd_q <= '0;
        end
      end
      ST_BCD: begin
        bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[AVG_W-1]};
        bin_q <= {bin_q[AVG_W-2:0], 1'b0};
        it_q  <= it_q + IT_W'(1);
      end
      ST_DONE: begin
        if (load_out) begin
          out_isv_q <= isv_q;
          out_avg_q <= avg_q;
          out_bcd_q <= bcd_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.is_voltage      = out_isv_q;
  assign res_o.average         = out_avg_q;
  assign res_o.digit_thousands = out_bcd_q[3*DIG_W +: DIG_W];
  assign res_o.digit_hundreds  = out_bcd_q[2*DIG_W +: DIG_W];
  assign res_o.digit_tens      = out_bcd_q[1*DIG_W +: DIG_W];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0))
    else $error("Division started with a zero count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_MUL))
    else $error("Popped job did not start the multiply step.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_o.digit_thousands <= DIG_W'(9) &&
                     res_o.digit_hundreds <= DIG_W'(9) &&
                     res_o.digit_tens <= DIG_W'(9)))
    else $error("Decimal digit out of range.");

endmodule

`default_nettype wire
